// ===== rtl/erdt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// erdt_pkg
// Shared types and constants of the event receiver dispatch table: command and
// result layouts, operation codes and the fixed field widths of the streams.
// ----------------------------------------------------------------------------
package erdt_pkg;

    localparam int RECEIVER_SLOTS_DEF = 16;
    localparam int RING_DEPTH_DEF     = 64;
    localparam int MAX_RESULTS        = 16;
    localparam int QUEUE_DEPTH        = 2;

    localparam int KIND_W      = 3;
    localparam int HANDLE_W    = 32;
    localparam int TASK_W      = 8;
    localparam int PAYLOAD_W   = 32;
    localparam int SLOT_OUT_W  = 4;
    localparam int POS_OUT_W   = 6;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_TUSER_W = 4;

    // Input kind codes as they arrive on the slave tuser.
    localparam logic [KIND_W-1:0] KIND_KEY    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MOUSE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FOCUS  = 3'd4;

    typedef enum logic [2:0] {
        OP_KEY,
        OP_MOUSE,
        OP_ADD,
        OP_REMOVE,
        OP_FOCUS
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        RES_DELIVERY = 3'd0,
        RES_ADDED    = 3'd1,
        RES_FULL     = 3'd2,
        RES_REMOVED  = 3'd3,
        RES_FOCUS    = 3'd4
    } res_kind_t;

    typedef struct packed {
        op_t                  op;
        logic [HANDLE_W-1:0]  handle;
        logic [TASK_W-1:0]    task_id;
        logic                 listen_always;
        logic [PAYLOAD_W-1:0] payload;
    } cmd_t;

    typedef struct packed {
        res_kind_t            result_kind;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [HANDLE_W-1:0]  out_buffer;
        logic [TASK_W-1:0]    deliver_task;
        logic [POS_OUT_W-1:0] write_position;
        logic [PAYLOAD_W-1:0] out_payload;
        logic                 key_flag;
        logic [TASK_W-1:0]    focused_now;
        logic                 last_result;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/erdt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// erdt_front
// Accepts input items, unpacks them and classifies the kind into an operation.
// Items of an undefined kind are taken and dropped here.
// ----------------------------------------------------------------------------
module erdt_front (
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [erdt_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [erdt_pkg::KIND_W-1:0]      s_tuser,
    input  wire logic                             q_full,
    output logic                                  push,
    output erdt_pkg::cmd_t                        push_cmd
);
    import erdt_pkg::*;

    logic known;
    op_t  op;

    always_comb
    begin
        known = 1'b1;
        op    = OP_KEY;
        case (s_tuser)
            KIND_KEY:    op = OP_KEY;
            KIND_MOUSE:  op = OP_MOUSE;
            KIND_ADD:    op = OP_ADD;
            KIND_REMOVE: op = OP_REMOVE;
            KIND_FOCUS:  op = OP_FOCUS;
            default:     known = 1'b0;
        endcase
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full && known;

    assign push_cmd.op            = op;
    assign push_cmd.handle        = s_tdata[31:0];
    assign push_cmd.task_id       = s_tdata[39:32];
    assign push_cmd.listen_always = s_tdata[40];
    assign push_cmd.payload       = s_tdata[72:41];

endmodule
`default_nettype wire

// ===== rtl/erdt_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// erdt_queue
// Short command queue between the front and the back of the block.
// ----------------------------------------------------------------------------
module erdt_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire erdt_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output erdt_pkg::cmd_t      pop_cmd,
    output logic                full,
    output logic                empty
);
    import erdt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/erdt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// erdt_back
// Carries out one command at a time; all but focus walk the receiver slots, one slot
// a cycle unless a delivery stalls, over a slot memory with a registered read port.
// ----------------------------------------------------------------------------
module erdt_back #(
    parameter int RECEIVER_SLOTS = erdt_pkg::RECEIVER_SLOTS_DEF,
    parameter int RING_DEPTH     = erdt_pkg::RING_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire erdt_pkg::cmd_t q_cmd,
    output logic                pop,
    input  wire logic           m_tready,
    output logic                m_tvalid,
    output erdt_pkg::result_t   res
);
    import erdt_pkg::*;

    localparam int SLOT_W = (RECEIVER_SLOTS > 1) ? $clog2(RECEIVER_SLOTS) : 1;
    localparam int POS_W  = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RECEIVER_SLOTS - 1);
    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(RING_DEPTH - 1);

    typedef struct packed {
        logic [HANDLE_W-1:0] buffer;
        logic [TASK_W-1:0]   owner;
        logic                always_on;
        logic [POS_W-1:0]    pos;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    entry_t mem [RECEIVER_SLOTS];
    entry_t rd_reg;

    state_t                    state_reg, state_next;
    logic [SLOT_W-1:0]         idx_reg, idx_next;
    logic [TASK_W-1:0]         focus_reg, focus_next;
    logic [RECEIVER_SLOTS-1:0] used_reg, used_next;
    logic                      held_valid_reg, held_valid_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;
    cmd_t                      cmd_reg, cmd_next;
    result_t                   held_reg, held_next;
    result_t                   out_reg, out_next;

    logic                 out_free;
    logic                 load_out;
    logic                 mem_we;
    entry_t               mem_wdata;
    logic                 is_key;
    logic                 hit;
    logic                 stall;
    logic                 last_slot;
    logic [POS_W-1:0]     new_pos;
    logic [SLOT_W+3:0]    slot_ext;
    logic [POS_W+5:0]     pos_ext;
    result_t              dres;

    assign out_free  = !out_valid_reg || m_tready;
    assign is_key    = (cmd_reg.op == OP_KEY);
    assign last_slot = (idx_reg == LAST_SLOT);
    assign new_pos   = (rd_reg.pos == LAST_POS) ? '0 : rd_reg.pos + 1'b1;
    assign slot_ext  = {4'b0, idx_reg};
    assign pos_ext   = {6'b0, new_pos};

    // A slot takes the event if it is in use and, for a key event, its owner
    // has the focus or it always listens. Past the result limit slots are skipped.
    assign hit = used_reg[idx_reg]
               && (!is_key || (rd_reg.owner == focus_reg) || rd_reg.always_on)
               && (cnt_reg < CNT_W'(MAX_RESULTS));

    // The previous delivery is held back until it is known whether it is the last.
    assign stall = hit && held_valid_reg && !out_free;

    always_comb
    begin
        dres                = '0;
        dres.result_kind    = RES_DELIVERY;
        dres.slot_index     = slot_ext[3:0];
        dres.out_buffer     = rd_reg.buffer;
        dres.deliver_task   = rd_reg.owner;
        dres.write_position = pos_ext[5:0];
        dres.out_payload    = cmd_reg.payload;
        dres.key_flag       = is_key;
        dres.focused_now    = focus_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        focus_next      = focus_reg;
        used_next       = used_reg;
        held_valid_next = held_valid_reg;
        cnt_next        = cnt_reg;
        cmd_next        = cmd_reg;
        held_next       = held_reg;
        out_next        = out_reg;
        load_out        = 1'b0;
        pop             = 1'b0;
        mem_we          = 1'b0;
        mem_wdata       = rd_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop             = 1'b1;
                    cmd_next        = q_cmd;
                    idx_next        = '0;
                    cnt_next        = '0;
                    held_valid_next = 1'b0;
                    state_next      = ST_SCAN;
                    if (q_cmd.op == OP_FOCUS)
                    begin
                        focus_next            = q_cmd.task_id;
                        held_next             = '0;
                        held_next.result_kind = RES_FOCUS;
                        held_valid_next       = 1'b1;
                        state_next            = ST_FINISH;
                    end
                end
            end

            ST_SCAN:
            begin
                case (cmd_reg.op)
                    OP_KEY, OP_MOUSE:
                    begin
                        if (!stall)
                        begin
                            if (hit)
                            begin
                                mem_we          = 1'b1;
                                mem_wdata.pos   = new_pos;
                                held_next       = dres;
                                held_valid_next = 1'b1;
                                cnt_next        = cnt_reg + 1'b1;
                                if (held_valid_reg)
                                begin
                                    load_out = 1'b1;
                                    out_next = held_reg;
                                end
                            end
                            if (last_slot)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                    end

                    OP_ADD:
                    begin
                        held_next       = '0;
                        if (!used_reg[idx_reg])
                        begin
                            // A zero handle fills the entry but leaves the slot free.
                            mem_we                   = 1'b1;
                            mem_wdata.buffer         = cmd_reg.handle;
                            mem_wdata.owner          = cmd_reg.task_id;
                            mem_wdata.always_on      = cmd_reg.listen_always;
                            mem_wdata.pos            = '0;
                            used_next[idx_reg]       = (cmd_reg.handle != '0);
                            held_next.result_kind    = RES_ADDED;
                            held_next.slot_index     = slot_ext[3:0];
                            held_next.out_buffer     = cmd_reg.handle;
                            held_next.deliver_task   = cmd_reg.task_id;
                            held_valid_next          = 1'b1;
                            state_next               = ST_FINISH;
                        end
                        else if (last_slot)
                        begin
                            held_next.result_kind = RES_FULL;
                            held_valid_next       = 1'b1;
                            state_next            = ST_FINISH;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end

                    OP_REMOVE:
                    begin
                        if (used_reg[idx_reg] && (cmd_reg.handle != '0)
                            && (rd_reg.buffer == cmd_reg.handle))
                        begin
                            used_next[idx_reg] = 1'b0;
                            if (rd_reg.owner == focus_reg)
                            begin
                                focus_next = '0;
                            end
                        end
                        if (last_slot)
                        begin
                            held_next             = '0;
                            held_next.result_kind = RES_REMOVED;
                            held_next.out_buffer  = cmd_reg.handle;
                            held_valid_next       = 1'b1;
                            state_next            = ST_FINISH;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end

                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_FINISH:
            begin
                if (!held_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    load_out             = 1'b1;
                    out_next             = held_reg;
                    out_next.focused_now = focus_reg;
                    out_next.last_result = 1'b1;
                    held_valid_next      = 1'b0;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            focus_reg      <= '0;
            used_reg       <= '0;
            held_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            focus_reg      <= focus_next;
            used_reg       <= used_next;
            held_valid_reg <= held_valid_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        held_reg <= held_next;
        out_reg  <= out_next;
    end

    // Slot memory: one write and one registered read a cycle. The read runs
    // one slot ahead of the slot being examined.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= mem_wdata;
        end
        rd_reg <= mem[idx_next];
    end

    assign m_tvalid = out_valid_reg;
    assign res      = out_reg;

endmodule
`default_nettype wire

// ===== rtl/event_receiver_dispatch_table_top.sv =====
`default_nettype none
// A remove, key or mouse item walks all RECEIVER_SLOTS slots at one slot a cycle,
// though a key or mouse walk is held while a delivery waits on the output; an add
// stops at the first free slot, and a focus item does not walk the slots. The back
// part finishes one item before it takes the next; the queue holds up to two items.
// Reset clears the slot-in-use bits and the focus; slot contents need no clearing.
// ----------------------------------------------------------------------------
// event_receiver_dispatch_table_top
// Receiver table with a focused task: adds and removes receivers, sets the
// focus and fans key and mouse events out to the matching receivers.
// ----------------------------------------------------------------------------
module event_receiver_dispatch_table_top #(
    parameter int RECEIVER_SLOTS = erdt_pkg::RECEIVER_SLOTS_DEF,
    parameter int RING_DEPTH     = erdt_pkg::RING_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // buffer_handle[31:0], task_id[39:32], listen_always[40], event_payload[72:41]
    input  wire logic [erdt_pkg::IN_TDATA_W-1:0]   s_tdata,
    // kind[2:0]
    input  wire logic [erdt_pkg::KIND_W-1:0]       s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // slot_index[3:0], out_buffer[35:4], deliver_task[43:36],
    // write_position[49:44], out_payload[81:50], focused_now[89:82]
    output logic [erdt_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // result_kind[2:0], key_flag[3]
    output logic [erdt_pkg::OUT_TUSER_W-1:0]       m_tuser,
    output logic                                   m_tlast
);
    import erdt_pkg::*;

    logic    q_full;
    logic    q_empty;
    logic    push;
    logic    pop;
    cmd_t    push_cmd;
    cmd_t    pop_cmd;
    result_t res;

    erdt_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    erdt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    erdt_back #(
        .RECEIVER_SLOTS (RECEIVER_SLOTS),
        .RING_DEPTH     (RING_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_cmd    (pop_cmd),
        .pop      (pop),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .res      (res)
    );

    assign m_tdata = {6'b0, res.focused_now, res.out_payload, res.write_position,
                      res.deliver_task, res.out_buffer, res.slot_index};
    assign m_tuser = {res.key_flag, res.result_kind};
    assign m_tlast = res.last_result;

endmodule
`default_nettype wire

// ===== rtl/erdt_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// erdt_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module erdt_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [erdt_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  wire logic [erdt_pkg::OUT_TUSER_W-1:0]  m_tuser,
    input  wire logic                              m_tlast
);
    import erdt_pkg::*;

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // Table and focus operations answer with exactly one item.
    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:0] != RES_DELIVERY) |-> m_tlast)
        else $error("table operation result not marked last");

    // Only deliveries carry an event word, a write position and a key flag.
    a_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[2:0] != RES_DELIVERY)
        |-> !m_tuser[3] && (m_tdata[81:50] == '0) && (m_tdata[49:44] == '0))
        else $error("non-delivery result carries delivery fields");

endmodule

bind event_receiver_dispatch_table_top erdt_checker u_erdt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
